// ----- rtl/core/rgb2s_pkg.sv -----
// ----------------------------------------------------------------------------
// rgb2s_pkg
// Shared types, constants and constant tables of the rgb to spectrum block:
// gamma decode rom, fixed srgb-to-xyz matrix, term expansion schedule.
// ----------------------------------------------------------------------------
package rgb2s_pkg;

	// block dimensions
	localparam int NUM_WAVELENGTHS = 401;
	localparam int NUM_CORR_TERMS  = 20;
	localparam int NUM_BASIS_TERMS = 7;
	localparam int ADAPT_DEPTH     = 9;
	localparam int CORR_DEPTH      = 3 * NUM_CORR_TERMS;
	localparam int BASIS_DEPTH     = NUM_WAVELENGTHS * NUM_BASIS_TERMS;
	localparam int ADAPT_AW        = $clog2(ADAPT_DEPTH);
	localparam int CORR_AW         = $clog2(CORR_DEPTH);
	localparam int BASIS_AW        = $clog2(BASIS_DEPTH);

	// field widths
	localparam int WL_W    = 9;
	localparam int IDX_W   = 12;
	localparam int COEF_W  = 32;
	localparam int PIX_W   = 8;
	localparam int DATA_W  = 64;
	localparam int PROD_W  = 128;
	localparam int OUT_W   = 32;
	localparam int GAMMA_W = 23;

	// scratch store layout (64-bit data words)
	localparam int SCR_DEPTH = 32;
	localparam int SCR_AW    = $clog2(SCR_DEPTH);
	localparam logic [SCR_AW-1:0] SCR_ONE = 5'd0;   // constant one, first term
	localparam logic [SCR_AW-1:0] SCR_XYZ = 5'd1;   // adapted xyz, terms 1..3
	localparam logic [SCR_AW-1:0] SCR_MID = 5'd20;  // raw xyz, later corrected xyz
	localparam logic [SCR_AW-1:0] SCR_RGB = 5'd23;  // linear rgb, later cross terms
	localparam logic [DATA_W-1:0] DATA_ONE = 64'd65536;

	// term expansion schedule: first expansion then second expansion
	localparam int NUM_TERMS = 20;
	localparam logic [4:0] TERM1_FIRST = 5'd0;
	localparam logic [4:0] TERM1_LAST  = 5'd15;
	localparam logic [4:0] TERM2_FIRST = 5'd16;
	localparam logic [4:0] TERM2_LAST  = 5'd19;
	localparam logic [SCR_AW-1:0] TERM_A [NUM_TERMS] = '{
		5'd1, 5'd2, 5'd1, 5'd1, 5'd2, 5'd3, 5'd4, 5'd7, 5'd8, 5'd9,
		5'd4, 5'd6, 5'd1, 5'd5, 5'd1, 5'd2, 5'd20, 5'd21, 5'd20, 5'd23};
	localparam logic [SCR_AW-1:0] TERM_B [NUM_TERMS] = '{
		5'd2, 5'd3, 5'd3, 5'd1, 5'd2, 5'd3, 5'd3, 5'd1, 5'd2, 5'd3,
		5'd2, 5'd3, 5'd4, 5'd3, 5'd6, 5'd5, 5'd21, 5'd22, 5'd22, 5'd22};
	localparam logic [SCR_AW-1:0] TERM_D [NUM_TERMS] = '{
		5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13,
		5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd23, 5'd24, 5'd25, 5'd26};

	// input codes
	localparam logic MODE_COEF  = 1'b0;
	localparam logic MODE_PIXEL = 1'b1;
	localparam logic [1:0] TSEL_ADAPT = 2'd0;
	localparam logic [1:0] TSEL_CORR  = 2'd1;
	localparam logic [1:0] TSEL_BASIS = 2'd2;

	typedef enum logic [1:0] {
		OP_ADAPT_WR,
		OP_CORR_WR,
		OP_BASIS_WR,
		OP_PIXEL
	} rgb2s_op_t;

	typedef struct packed {
		rgb2s_op_t          op;
		logic [IDX_W-1:0]   idx;
		logic [COEF_W-1:0]  value;
		logic [PIX_W-1:0]   red;
		logic [PIX_W-1:0]   green;
		logic [PIX_W-1:0]   blue;
	} rgb2s_item_t;

	typedef struct packed {
		logic        valid;
		rgb2s_item_t item;
	} rgb2s_head_t;

	typedef enum logic [2:0] {
		PH_SRGB,
		PH_ADAPT,
		PH_TERM1,
		PH_CORR,
		PH_TERM2,
		PH_BASIS
	} rgb2s_phase_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_GAMMA,
		BK_RD,
		BK_LOAD,
		BK_MUL,
		BK_SAT,
		BK_ACC,
		BK_ROUND,
		BK_WR,
		BK_OUT
	} rgb2s_bk_state_t;

	// published matrix entry times 2^24, rounded
	function automatic logic [COEF_W-1:0] q24c(input longint n);
		return COEF_W'((n * 64'sd16777216 + 64'sd5000000) / 64'sd10000000);
	endfunction

	localparam logic [COEF_W-1:0] SRGB_XYZ [ADAPT_DEPTH] = '{
		q24c(4124564), q24c(3575761), q24c(1804375),
		q24c(2126729), q24c(7151522), q24c(721750),
		q24c(193339),  q24c(1191920), q24c(9503041)};

	// q30 product
	function automatic logic [63:0] q30(input logic [63:0] a, input logic [63:0] b);
		return (a * b) >> 30;
	endfunction

	// one gamma entry, linear light times 100 in q16.16
	function automatic logic [GAMMA_W-1:0] gamma_entry(input int c);
		logic [63:0] t;
		logic [63:0] t2;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		logic [63:0] y2;
		logic [63:0] p5;
		if (c <= 10) begin
			return GAMMA_W'((64'(c) * 64'd65536000 + 64'd16473) / 64'd32946);
		end
		t  = ((64'd1000 * 64'(c) + 64'd14025) << 30) / 64'd269025;
		t2 = q30(t, t);
		lo = 64'd0;
		hi = 64'd1 << 30;
		for (int i = 0; i < 32; i++) begin
			if (lo < hi) begin
				mid = (lo + hi + 64'd1) >> 1;
				y2  = q30(mid, mid);
				p5  = q30(q30(y2, y2), mid);
				if (p5 <= t2) lo = mid;
				else hi = mid - 64'd1;
			end
		end
		return GAMMA_W'((q30(t2, lo) * 64'd100 + 64'd8192) >> 14);
	endfunction

	function automatic logic [256*GAMMA_W-1:0] gamma_build();
		logic [256*GAMMA_W-1:0] r;
		r = '0;
		for (int c = 0; c < 256; c++) r[c*GAMMA_W +: GAMMA_W] = gamma_entry(c);
		return r;
	endfunction

	localparam logic [256*GAMMA_W-1:0] GAMMA_ROM = gamma_build();

	function automatic logic [GAMMA_W-1:0] gamma_lut(input logic [PIX_W-1:0] c);
		return GAMMA_ROM[c*GAMMA_W +: GAMMA_W];
	endfunction

endpackage

// ----- rtl/core/rgb2s_ram.sv -----
// ----------------------------------------------------------------------------
// rgb2s_ram
// Generic single-write, single-read ram with registered read data.
// ----------------------------------------------------------------------------
module rgb2s_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/rgb2s_front.sv -----
// ----------------------------------------------------------------------------
// rgb2s_front
// Accepts input items, sorts them into coefficient writes and pixels, drops
// writes that hit no table entry, and queues the rest for the back end.
// ----------------------------------------------------------------------------
module rgb2s_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          mode,
	input  logic [1:0]                    table_select,
	input  logic [rgb2s_pkg::IDX_W-1:0]   coef_index,
	input  logic [rgb2s_pkg::COEF_W-1:0]  coef_value,
	input  logic [rgb2s_pkg::PIX_W-1:0]   red,
	input  logic [rgb2s_pkg::PIX_W-1:0]   green,
	input  logic [rgb2s_pkg::PIX_W-1:0]   blue,
	output rgb2s_pkg::rgb2s_head_t        head,
	input  logic                          pop
);

	rgb2s_pkg::rgb2s_item_t items_q [2];
	rgb2s_pkg::rgb2s_item_t item;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       keep;
	logic       push;

	// classify the incoming item
	always_comb begin
		keep = 1'b1;
		item.op = rgb2s_pkg::OP_PIXEL;
		if (mode == rgb2s_pkg::MODE_COEF) begin
			case (table_select)
				rgb2s_pkg::TSEL_ADAPT: begin
					item.op = rgb2s_pkg::OP_ADAPT_WR;
					keep = 32'(coef_index) < 32'(rgb2s_pkg::ADAPT_DEPTH);
				end
				rgb2s_pkg::TSEL_CORR: begin
					item.op = rgb2s_pkg::OP_CORR_WR;
					keep = 32'(coef_index) < 32'(rgb2s_pkg::CORR_DEPTH);
				end
				rgb2s_pkg::TSEL_BASIS: begin
					item.op = rgb2s_pkg::OP_BASIS_WR;
					keep = 32'(coef_index) < 32'(rgb2s_pkg::BASIS_DEPTH);
				end
				default: begin
					keep = 1'b0;
				end
			endcase
		end
		item.idx   = coef_index;
		item.value = coef_value;
		item.red   = red;
		item.green = green;
		item.blue  = blue;
	end

	assign in_stall = count_q[1];
	assign push = in_valid && !in_stall && keep;

	// two-entry queue toward the back end
	always_ff @(posedge clk) begin
		if (push) items_q[wr_ptr_q] <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign head.valid = (count_q != 2'd0);
	assign head.item  = items_q[rd_ptr_q];

endmodule

// ----- rtl/core/rgb2s_back.sv -----
// ----------------------------------------------------------------------------
// rgb2s_back
// Carries out queued items: coefficient writes into the stores, and the
// per-pixel sequence of matrix rows and term products on one shared
// 32x32 multiplier with 64-bit saturating accumulation.
// ----------------------------------------------------------------------------
module rgb2s_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rgb2s_pkg::rgb2s_head_t          head,
	output logic                            pop,
	input  logic [rgb2s_pkg::WL_W-1:0]      wl,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [rgb2s_pkg::OUT_W-1:0]     spectral_value,
	output logic                            saturated
);

	localparam int BASE_W = rgb2s_pkg::BASIS_AW + rgb2s_pkg::WL_W;

	rgb2s_pkg::rgb2s_bk_state_t state_q, state_d;
	rgb2s_pkg::rgb2s_phase_t    phase_q, phase_next;

	logic [3*rgb2s_pkg::PIX_W-1:0]   pix_q;
	logic [1:0]                      g_q;
	logic [4:0]                      k_q;
	logic [1:0]                      row_q;
	logic [4:0]                      t_q;
	logic [rgb2s_pkg::BASIS_AW-1:0]  cidx_q;
	logic [rgb2s_pkg::DATA_W-1:0]    acc_q;
	logic [rgb2s_pkg::DATA_W-1:0]    mag_a_q;
	logic [rgb2s_pkg::DATA_W-1:0]    mag_b_q;
	logic                            neg_q;
	logic [1:0]                      pp_q;
	logic [rgb2s_pkg::PROD_W-1:0]    prod_q;
	logic [rgb2s_pkg::DATA_W-1:0]    p_q;
	logic                            sat_q;
	logic                            out_valid_q;
	logic [rgb2s_pkg::OUT_W-1:0]     out_value_q;
	logic                            out_sat_q;

	// phase parameters
	logic [4:0]                   k_last;
	logic [1:0]                   row_last;
	logic [rgb2s_pkg::SCR_AW-1:0] data_base;
	logic [rgb2s_pkg::SCR_AW-1:0] dst_base;
	logic                         is_term;
	logic [4:0]                   term_last;
	logic                         phase_adv;

	// store ports
	logic                               adapt_we, corr_we, basis_we, scr_we;
	logic [rgb2s_pkg::COEF_W-1:0]       adapt_rdata, corr_rdata, basis_rdata;
	logic [rgb2s_pkg::SCR_AW-1:0]       scr_waddr, scr_raddr_a, scr_raddr_b;
	logic [rgb2s_pkg::DATA_W-1:0]       scr_wdata, scr_rdata_a, scr_rdata_b;

	// datapath nets
	logic [BASE_W-1:0]                  wl_ext;
	logic [BASE_W-1:0]                  base_full;
	logic [rgb2s_pkg::BASIS_AW-1:0]     basis_base;
	logic [rgb2s_pkg::COEF_W-1:0]       coef_sel;
	logic [rgb2s_pkg::DATA_W-1:0]       op_a, op_b;
	logic [31:0]                        half_a, half_b;
	logic [63:0]                        pp;
	logic [1:0]                         pp_sh;
	logic [rgb2s_pkg::PROD_W-1:0]       pp_shifted;
	logic [rgb2s_pkg::PROD_W-1:0]       rnd;
	logic [rgb2s_pkg::DATA_W-1:0]       limit, pmag, pval;
	logic                               p_ovf;
	logic [rgb2s_pkg::DATA_W-1:0]       sum;
	logic                               acc_ovf;
	logic [rgb2s_pkg::DATA_W-1:0]       acc_next;
	logic [rgb2s_pkg::DATA_W-1:0]       amag, rmag, rval;
	logic [rgb2s_pkg::PIX_W-1:0]        pix_cur;
	logic                               out_fits;
	logic                               out_take;

	// coefficient stores and scratch data (two copies for two read ports)
	rgb2s_ram #(.WIDTH(rgb2s_pkg::COEF_W), .DEPTH(rgb2s_pkg::ADAPT_DEPTH)) u_adapt (
		.clk(clk), .we(adapt_we),
		.waddr(rgb2s_pkg::ADAPT_AW'(head.item.idx)), .wdata(head.item.value),
		.raddr(rgb2s_pkg::ADAPT_AW'(cidx_q)), .rdata(adapt_rdata)
	);

	rgb2s_ram #(.WIDTH(rgb2s_pkg::COEF_W), .DEPTH(rgb2s_pkg::CORR_DEPTH)) u_corr (
		.clk(clk), .we(corr_we),
		.waddr(rgb2s_pkg::CORR_AW'(head.item.idx)), .wdata(head.item.value),
		.raddr(rgb2s_pkg::CORR_AW'(cidx_q)), .rdata(corr_rdata)
	);

	rgb2s_ram #(.WIDTH(rgb2s_pkg::COEF_W), .DEPTH(rgb2s_pkg::BASIS_DEPTH)) u_basis (
		.clk(clk), .we(basis_we),
		.waddr(rgb2s_pkg::BASIS_AW'(head.item.idx)), .wdata(head.item.value),
		.raddr(cidx_q), .rdata(basis_rdata)
	);

	rgb2s_ram #(.WIDTH(rgb2s_pkg::DATA_W), .DEPTH(rgb2s_pkg::SCR_DEPTH)) u_scr_a (
		.clk(clk), .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
		.raddr(scr_raddr_a), .rdata(scr_rdata_a)
	);

	rgb2s_ram #(.WIDTH(rgb2s_pkg::DATA_W), .DEPTH(rgb2s_pkg::SCR_DEPTH)) u_scr_b (
		.clk(clk), .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
		.raddr(scr_raddr_b), .rdata(scr_rdata_b)
	);

	// per-phase row length, row count and scratch addresses
	always_comb begin
		k_last     = 5'd0;
		row_last   = 2'd0;
		data_base  = rgb2s_pkg::SCR_ONE;
		dst_base   = rgb2s_pkg::SCR_MID;
		phase_next = rgb2s_pkg::PH_BASIS;
		case (phase_q)
			rgb2s_pkg::PH_SRGB: begin
				k_last = 5'd2; row_last = 2'd2;
				data_base = rgb2s_pkg::SCR_RGB; dst_base = rgb2s_pkg::SCR_MID;
				phase_next = rgb2s_pkg::PH_ADAPT;
			end
			rgb2s_pkg::PH_ADAPT: begin
				k_last = 5'd2; row_last = 2'd2;
				data_base = rgb2s_pkg::SCR_MID; dst_base = rgb2s_pkg::SCR_XYZ;
				phase_next = rgb2s_pkg::PH_TERM1;
			end
			rgb2s_pkg::PH_TERM1: begin
				phase_next = rgb2s_pkg::PH_CORR;
			end
			rgb2s_pkg::PH_CORR: begin
				k_last = 5'(rgb2s_pkg::NUM_CORR_TERMS - 1); row_last = 2'd2;
				data_base = rgb2s_pkg::SCR_ONE; dst_base = rgb2s_pkg::SCR_MID;
				phase_next = rgb2s_pkg::PH_TERM2;
			end
			rgb2s_pkg::PH_TERM2: begin
				phase_next = rgb2s_pkg::PH_BASIS;
			end
			rgb2s_pkg::PH_BASIS: begin
				k_last = 5'(rgb2s_pkg::NUM_BASIS_TERMS - 1); row_last = 2'd0;
				data_base = rgb2s_pkg::SCR_MID;
			end
			default: begin
				k_last = 5'd0;
			end
		endcase
	end

	assign is_term = (phase_q == rgb2s_pkg::PH_TERM1) || (phase_q == rgb2s_pkg::PH_TERM2);
	assign term_last = (phase_q == rgb2s_pkg::PH_TERM1) ? rgb2s_pkg::TERM1_LAST
		: rgb2s_pkg::TERM2_LAST;
	assign phase_adv = ((state_q == rgb2s_pkg::BK_ROUND) && (row_q == row_last)
		&& (phase_q != rgb2s_pkg::PH_BASIS))
		|| ((state_q == rgb2s_pkg::BK_WR) && (t_q == term_last));

	// first basis element of the selected wavelength, clamped to the last row
	always_comb begin
		wl_ext = BASE_W'(wl);
		if (wl_ext >= BASE_W'(rgb2s_pkg::NUM_WAVELENGTHS))
			wl_ext = BASE_W'(rgb2s_pkg::NUM_WAVELENGTHS - 1);
		base_full = wl_ext * BASE_W'(rgb2s_pkg::NUM_BASIS_TERMS);
	end
	assign basis_base = rgb2s_pkg::BASIS_AW'(base_full);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rgb2s_pkg::BK_IDLE: begin
				if (head.valid && (head.item.op == rgb2s_pkg::OP_PIXEL))
					state_d = rgb2s_pkg::BK_GAMMA;
			end
			rgb2s_pkg::BK_GAMMA: begin
				if (g_q == 2'd3) state_d = rgb2s_pkg::BK_RD;
			end
			rgb2s_pkg::BK_RD: state_d = rgb2s_pkg::BK_LOAD;
			rgb2s_pkg::BK_LOAD: state_d = rgb2s_pkg::BK_MUL;
			rgb2s_pkg::BK_MUL: begin
				if (pp_q == 2'd3) state_d = rgb2s_pkg::BK_SAT;
			end
			rgb2s_pkg::BK_SAT: state_d = is_term ? rgb2s_pkg::BK_WR : rgb2s_pkg::BK_ACC;
			rgb2s_pkg::BK_ACC: begin
				state_d = (k_q == k_last) ? rgb2s_pkg::BK_ROUND : rgb2s_pkg::BK_RD;
			end
			rgb2s_pkg::BK_ROUND: begin
				state_d = (phase_q == rgb2s_pkg::PH_BASIS) ? rgb2s_pkg::BK_OUT
					: rgb2s_pkg::BK_RD;
			end
			rgb2s_pkg::BK_WR: state_d = rgb2s_pkg::BK_RD;
			rgb2s_pkg::BK_OUT: begin
				if (!out_valid_q || !out_stall) state_d = rgb2s_pkg::BK_IDLE;
			end
			default: state_d = rgb2s_pkg::BK_IDLE;
		endcase
	end

	// store controls and scratch addressing
	always_comb begin
		pop       = 1'b0;
		adapt_we  = 1'b0;
		corr_we   = 1'b0;
		basis_we  = 1'b0;
		scr_we    = 1'b0;
		scr_waddr = rgb2s_pkg::SCR_ONE;
		scr_wdata = p_q;
		out_take  = 1'b0;
		case (state_q)
			rgb2s_pkg::BK_IDLE: begin
				pop = head.valid;
				adapt_we = head.valid && (head.item.op == rgb2s_pkg::OP_ADAPT_WR);
				corr_we  = head.valid && (head.item.op == rgb2s_pkg::OP_CORR_WR);
				basis_we = head.valid && (head.item.op == rgb2s_pkg::OP_BASIS_WR);
			end
			rgb2s_pkg::BK_GAMMA: begin
				scr_we = 1'b1;
				if (g_q == 2'd3) begin
					scr_waddr = rgb2s_pkg::SCR_ONE;
					scr_wdata = rgb2s_pkg::DATA_ONE;
				end else begin
					scr_waddr = rgb2s_pkg::SCR_RGB + rgb2s_pkg::SCR_AW'(g_q);
					scr_wdata = rgb2s_pkg::DATA_W'(rgb2s_pkg::gamma_lut(pix_cur));
				end
			end
			rgb2s_pkg::BK_ROUND: begin
				scr_we    = (phase_q != rgb2s_pkg::PH_BASIS);
				scr_waddr = dst_base + rgb2s_pkg::SCR_AW'(row_q);
				scr_wdata = rval;
			end
			rgb2s_pkg::BK_WR: begin
				scr_we    = 1'b1;
				scr_waddr = rgb2s_pkg::TERM_D[t_q];
				scr_wdata = p_q;
			end
			rgb2s_pkg::BK_OUT: begin
				out_take = !out_valid_q || !out_stall;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	assign scr_raddr_a = rgb2s_pkg::TERM_A[t_q];
	assign scr_raddr_b = is_term ? rgb2s_pkg::TERM_B[t_q]
		: data_base + rgb2s_pkg::SCR_AW'(k_q);

	// pixel component for the gamma step
	always_comb begin
		case (g_q)
			2'd0:    pix_cur = pix_q[3*rgb2s_pkg::PIX_W-1 -: rgb2s_pkg::PIX_W];
			2'd1:    pix_cur = pix_q[2*rgb2s_pkg::PIX_W-1 -: rgb2s_pkg::PIX_W];
			default: pix_cur = pix_q[rgb2s_pkg::PIX_W-1:0];
		endcase
	end

	// operand select and magnitudes
	always_comb begin
		case (phase_q)
			rgb2s_pkg::PH_SRGB:  coef_sel = rgb2s_pkg::SRGB_XYZ[rgb2s_pkg::ADAPT_AW'(cidx_q)];
			rgb2s_pkg::PH_ADAPT: coef_sel = adapt_rdata;
			rgb2s_pkg::PH_CORR:  coef_sel = corr_rdata;
			default:             coef_sel = basis_rdata;
		endcase
		op_a = is_term ? scr_rdata_a
			: {{(rgb2s_pkg::DATA_W-rgb2s_pkg::COEF_W){coef_sel[rgb2s_pkg::COEF_W-1]}},
			coef_sel};
		op_b = scr_rdata_b;
	end

	// one 32x32 partial product per cycle
	always_comb begin
		half_a = pp_q[1] ? mag_a_q[63:32] : mag_a_q[31:0];
		half_b = pp_q[0] ? mag_b_q[63:32] : mag_b_q[31:0];
		pp     = half_a * half_b;
		pp_sh  = {1'b0, pp_q[1]} + {1'b0, pp_q[0]};
		case (pp_sh)
			2'd0:    pp_shifted = {64'd0, pp};
			2'd1:    pp_shifted = {32'd0, pp, 32'd0};
			default: pp_shifted = {pp, 64'd0};
		endcase
	end

	// product rounding (term phases only) and saturation
	always_comb begin
		rnd   = is_term ? ((prod_q + 128'h8000) >> 16) : prod_q;
		limit = neg_q ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
		p_ovf = (|rnd[127:64]) || (rnd[63:0] > limit);
		pmag  = p_ovf ? limit : rnd[63:0];
		pval  = neg_q ? -pmag : pmag;
	end

	// saturating accumulate
	always_comb begin
		sum     = acc_q + p_q;
		acc_ovf = (acc_q[63] == p_q[63]) && (sum[63] != acc_q[63]);
		acc_next = acc_ovf ? (p_q[63] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff)
			: sum;
	end

	// row rounding, ties away from zero
	always_comb begin
		amag = acc_q[63] ? -acc_q : acc_q;
		rmag = (amag + 64'h80_0000) >> 24;
		rval = acc_q[63] ? -rmag : rmag;
	end

	assign out_fits = (&p_q[63:31]) || !(|p_q[63:31]);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rgb2s_pkg::BK_IDLE;
			phase_q     <= rgb2s_pkg::PH_SRGB;
			g_q         <= 2'd0;
			k_q         <= 5'd0;
			row_q       <= 2'd0;
			t_q         <= 5'd0;
			pp_q        <= 2'd0;
			cidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (phase_adv) begin
				phase_q <= phase_next;
				k_q     <= 5'd0;
				row_q   <= 2'd0;
				cidx_q  <= (phase_next == rgb2s_pkg::PH_BASIS) ? basis_base : '0;
				t_q     <= (phase_next == rgb2s_pkg::PH_TERM2) ? rgb2s_pkg::TERM2_FIRST
					: rgb2s_pkg::TERM1_FIRST;
			end else begin
				case (state_q)
					rgb2s_pkg::BK_IDLE: begin
						g_q     <= 2'd0;
						phase_q <= rgb2s_pkg::PH_SRGB;
						k_q     <= 5'd0;
						row_q   <= 2'd0;
						cidx_q  <= '0;
					end
					rgb2s_pkg::BK_GAMMA: g_q <= g_q + 2'd1;
					rgb2s_pkg::BK_LOAD:  pp_q <= 2'd0;
					rgb2s_pkg::BK_MUL:   pp_q <= pp_q + 2'd1;
					rgb2s_pkg::BK_ACC: begin
						k_q    <= k_q + 5'd1;
						cidx_q <= cidx_q + 1'b1;
					end
					rgb2s_pkg::BK_ROUND: begin
						k_q   <= 5'd0;
						row_q <= row_q + 2'd1;
					end
					rgb2s_pkg::BK_WR: t_q <= t_q + 5'd1;
					default: begin
						pp_q <= pp_q;
					end
				endcase
			end
			if (out_take) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			rgb2s_pkg::BK_IDLE: begin
				pix_q <= {head.item.red, head.item.green, head.item.blue};
				sat_q <= 1'b0;
				acc_q <= '0;
			end
			rgb2s_pkg::BK_LOAD: begin
				mag_a_q <= op_a[63] ? -op_a : op_a;
				mag_b_q <= op_b[63] ? -op_b : op_b;
				neg_q   <= op_a[63] ^ op_b[63];
				prod_q  <= '0;
			end
			rgb2s_pkg::BK_MUL: prod_q <= prod_q + pp_shifted;
			rgb2s_pkg::BK_SAT: begin
				p_q   <= pval;
				sat_q <= sat_q | p_ovf;
			end
			rgb2s_pkg::BK_ACC: begin
				acc_q <= acc_next;
				sat_q <= sat_q | acc_ovf;
			end
			rgb2s_pkg::BK_ROUND: begin
				acc_q <= '0;
				p_q   <= rval;
			end
			default: begin
				sat_q <= sat_q;
			end
		endcase
		if (out_take) begin
			out_value_q <= out_fits ? p_q[31:0]
				: (p_q[63] ? 32'h8000_0000 : 32'h7fff_ffff);
			out_sat_q   <= sat_q | !out_fits;
		end
	end

	assign out_valid      = out_valid_q;
	assign spectral_value = out_value_q;
	assign saturated      = out_sat_q;

endmodule

// ----- rtl/core/rgb_to_spectral_reconstruction_top.sv -----
// ----------------------------------------------------------------------------
// rgb_to_spectral_reconstruction_top
// Each pixel takes 105 multiplies on the shared multiplier, four partial
// products per multiply; the back end takes no new item until the pixel's
// result is loaded into the output register. Coefficient writes go at one
// per cycle while no pixel is in progress; ignored writes never reach the back end.
// Reset clears control state and sets the wavelength index to 0; stored
// coefficients stay undefined until written, with no clearing pass.
// ----------------------------------------------------------------------------
module rgb_to_spectral_reconstruction_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rgb2s_pkg::WL_W-1:0]    wavelength_index,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          mode,
	input  logic [1:0]                    table_select,
	input  logic [rgb2s_pkg::IDX_W-1:0]   coef_index,
	input  logic [rgb2s_pkg::COEF_W-1:0]  coef_value,
	input  logic [rgb2s_pkg::PIX_W-1:0]   red,
	input  logic [rgb2s_pkg::PIX_W-1:0]   green,
	input  logic [rgb2s_pkg::PIX_W-1:0]   blue,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [rgb2s_pkg::OUT_W-1:0]   spectral_value,
	output logic                          saturated
);

	rgb2s_pkg::rgb2s_head_t     head;
	logic                       pop;
	logic [rgb2s_pkg::WL_W-1:0] wl_q;

	// wavelength register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) wl_q <= '0;
		else if (cfg_valid && cfg_ready) wl_q <= wavelength_index;
	end

	// front end: accept, classify, queue
	rgb2s_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .table_select(table_select), .coef_index(coef_index),
		.coef_value(coef_value), .red(red), .green(green), .blue(blue),
		.head(head), .pop(pop)
	);

	// back end: stores and arithmetic sequence
	rgb2s_back u_back (
		.clk(clk), .arst_n(arst_n),
		.head(head), .pop(pop), .wl(wl_q),
		.out_valid(out_valid), .out_stall(out_stall),
		.spectral_value(spectral_value), .saturated(saturated)
	);

endmodule

// ----- tb/tb_rgb_to_spectral_reconstruction_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_to_spectral_reconstruction_top
// Self-checking bench for the rgb to spectrum block: loads the matrix stores
// and the basis rows of every wavelength used, then runs directed and random
// pixel and coefficient traffic under several idle and stall mixes and
// wavelength settings, and checks each result against a bit-true fixed-point
// predictor of the pipeline.
// ----------------------------------------------------------------------------
module tb_rgb_to_spectral_reconstruction_top;

	localparam int WDOG_LIMIT = 20000;

	typedef struct {
		logic                         mode;
		logic [1:0]                   tsel;
		logic [rgb2s_pkg::IDX_W-1:0]  idx;
		logic [rgb2s_pkg::COEF_W-1:0] value;
		logic [rgb2s_pkg::PIX_W-1:0]  r;
		logic [rgb2s_pkg::PIX_W-1:0]  g;
		logic [rgb2s_pkg::PIX_W-1:0]  b;
	} stim_t;

	typedef struct {
		logic [rgb2s_pkg::OUT_W-1:0] value;
		logic                        sat;
	} spec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [rgb2s_pkg::WL_W-1:0] wavelength_index = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic mode = 1'b0;
	logic [1:0] table_select = '0;
	logic [rgb2s_pkg::IDX_W-1:0] coef_index = '0;
	logic [rgb2s_pkg::COEF_W-1:0] coef_value = '0;
	logic [rgb2s_pkg::PIX_W-1:0] red = '0;
	logic [rgb2s_pkg::PIX_W-1:0] green = '0;
	logic [rgb2s_pkg::PIX_W-1:0] blue = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [rgb2s_pkg::OUT_W-1:0] spectral_value;
	logic saturated;

	// bench state
	stim_t pending_items[$];
	spec_t spectra_due[$];
	logic in_fire = 1'b0;
	int send_idle = 0;
	int recv_idle = 0;
	int errors = 0;
	int pixels_checked = 0;
	int coef_writes = 0;
	int sat_results = 0;
	int quiet_cycles = 0;

	// predictor copy of the block
	logic [rgb2s_pkg::COEF_W-1:0] adapt_m[rgb2s_pkg::ADAPT_DEPTH];
	logic [rgb2s_pkg::COEF_W-1:0] corr_m[rgb2s_pkg::CORR_DEPTH];
	logic [rgb2s_pkg::COEF_W-1:0] basis_m[rgb2s_pkg::BASIS_DEPTH];
	logic [rgb2s_pkg::WL_W-1:0] wl_sel = '0;
	longint gamma_tab[256];
	longint xyz_fix[9];
	bit px_sat;

	always #6 clk = ~clk;

	rgb_to_spectral_reconstruction_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .wavelength_index(wavelength_index),
		.in_valid(in_valid), .in_stall(in_stall), .mode(mode), .table_select(table_select),
		.coef_index(coef_index), .coef_value(coef_value),
		.red(red), .green(green), .blue(blue),
		.out_valid(out_valid), .out_stall(out_stall),
		.spectral_value(spectral_value), .saturated(saturated)
	);

	// q30 fixed-point product, unsigned
	function automatic logic [63:0] qmul30(logic [63:0] a, logic [63:0] b);
		return (a * b) >> 30;
	endfunction

	// gamma decode times 100, q16.16
	function automatic longint gamma_calc(int c);
		logic [63:0] t, t2, lo, hi, mid, y2;
		if (c <= 10) return longint'((64'(c) * 64'd65536000 + 64'd16473) / 64'd32946);
		t = ((64'd1000 * 64'(c) + 64'd14025) << 30) / 64'd269025;
		t2 = qmul30(t, t);
		lo = 0;
		hi = 64'd1 << 30;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			y2 = qmul30(mid, mid);
			if (qmul30(qmul30(y2, y2), mid) <= t2) lo = mid;
			else hi = mid - 1;
		end
		return longint'((qmul30(t2, lo) * 64'd100 + 64'd8192) >> 14);
	endfunction

	// product shifted right with round half away, clipped to int64
	function automatic longint mul_rnd(longint a, longint b, int s);
		logic neg;
		logic [63:0] ua, ub, lim;
		logic [127:0] p;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		p = {64'd0, ua} * {64'd0, ub};
		if (s > 0) p = (p + (128'd1 << (s - 1))) >> s;
		lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
		if (p > {64'd0, lim}) begin
			px_sat = 1'b1;
			p = {64'd0, lim};
		end
		return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic longint add_clip(longint a, longint b);
		longint r;
		r = a + b;
		if (a[63] == b[63] && r[63] != a[63]) begin
			px_sat = 1'b1;
			return a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
		end
		return r;
	endfunction

	function automatic longint rnd24(longint v);
		logic [63:0] m;
		m = ((v < 0) ? -v : v);
		m = (m + 64'd8388608) >> 24;
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint sx(logic [31:0] w);
		return longint'(signed'(w));
	endfunction

	// full pipeline for one pixel
	function automatic spec_t predict_spectrum(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		longint lin[3], x0[3], xa[3], e1[20], cx[3], e2[7];
		longint acc;
		int w;
		spec_t res;
		px_sat = 1'b0;
		lin[0] = gamma_tab[r];
		lin[1] = gamma_tab[g];
		lin[2] = gamma_tab[b];
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int k = 0; k < 3; k++) acc = add_clip(acc, mul_rnd(xyz_fix[i*3+k], lin[k], 0));
			x0[i] = rnd24(acc);
		end
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int k = 0; k < 3; k++) acc = add_clip(acc, mul_rnd(sx(adapt_m[i*3+k]), x0[k], 0));
			xa[i] = rnd24(acc);
		end
		// first polynomial expansion
		e1[0] = 65536; e1[1] = xa[0]; e1[2] = xa[1]; e1[3] = xa[2];
		e1[4] = mul_rnd(xa[0], xa[1], 16);
		e1[5] = mul_rnd(xa[1], xa[2], 16);
		e1[6] = mul_rnd(xa[0], xa[2], 16);
		e1[7] = mul_rnd(xa[0], xa[0], 16);
		e1[8] = mul_rnd(xa[1], xa[1], 16);
		e1[9] = mul_rnd(xa[2], xa[2], 16);
		e1[10] = mul_rnd(e1[4], xa[2], 16);
		e1[11] = mul_rnd(e1[7], xa[0], 16);
		e1[12] = mul_rnd(e1[8], xa[1], 16);
		e1[13] = mul_rnd(e1[9], xa[2], 16);
		e1[14] = mul_rnd(e1[4], xa[1], 16);
		e1[15] = mul_rnd(e1[6], xa[2], 16);
		e1[16] = mul_rnd(xa[0], e1[4], 16);
		e1[17] = mul_rnd(e1[5], xa[2], 16);
		e1[18] = mul_rnd(xa[0], e1[6], 16);
		e1[19] = mul_rnd(xa[1], e1[5], 16);
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int k = 0; k < rgb2s_pkg::NUM_CORR_TERMS; k++)
				acc = add_clip(acc,
					mul_rnd(sx(corr_m[i*rgb2s_pkg::NUM_CORR_TERMS+k]), e1[k], 0));
			cx[i] = rnd24(acc);
		end
		// second expansion
		e2[0] = cx[0]; e2[1] = cx[1]; e2[2] = cx[2];
		e2[3] = mul_rnd(cx[0], cx[1], 16);
		e2[4] = mul_rnd(cx[1], cx[2], 16);
		e2[5] = mul_rnd(cx[0], cx[2], 16);
		e2[6] = mul_rnd(e2[3], cx[2], 16);
		w = (wl_sel >= rgb2s_pkg::NUM_WAVELENGTHS) ? rgb2s_pkg::NUM_WAVELENGTHS - 1
			: int'(wl_sel);
		acc = 0;
		for (int k = 0; k < rgb2s_pkg::NUM_BASIS_TERMS; k++)
			acc = add_clip(acc,
				mul_rnd(sx(basis_m[w*rgb2s_pkg::NUM_BASIS_TERMS+k]), e2[k], 0));
		acc = rnd24(acc);
		if (acc > 64'sd2147483647) begin
			acc = 64'sd2147483647;
			px_sat = 1'b1;
		end
		if (acc < -64'sd2147483648) begin
			acc = -64'sd2147483648;
			px_sat = 1'b1;
		end
		res.value = acc[31:0];
		res.sat = px_sat;
		return res;
	endfunction

	// apply one accepted input transfer to the predictor
	task automatic absorb_item(stim_t it);
		if (it.mode == rgb2s_pkg::MODE_PIXEL) begin
			spectra_due.push_back(predict_spectrum(it.r, it.g, it.b));
		end else begin
			coef_writes++;
			if (it.tsel == rgb2s_pkg::TSEL_ADAPT && it.idx < rgb2s_pkg::ADAPT_DEPTH)
				adapt_m[it.idx] = it.value;
			else if (it.tsel == rgb2s_pkg::TSEL_CORR && it.idx < rgb2s_pkg::CORR_DEPTH)
				corr_m[it.idx] = it.value;
			else if (it.tsel == rgb2s_pkg::TSEL_BASIS && it.idx < rgb2s_pkg::BASIS_DEPTH)
				basis_m[it.idx] = it.value;
		end
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic logic [31:0] pick_coef();
		int k;
		logic [31:0] r;
		k = $urandom_range(9);
		r = $urandom;
		if (k < 6) return {{7{r[24]}}, r[24:0]};
		if (k < 8) return {{11{r[20]}}, r[20:0]};
		return r;
	endfunction

	function automatic stim_t coef_item(logic [1:0] tsel, int idx, logic [31:0] v);
		stim_t it;
		it.mode = rgb2s_pkg::MODE_COEF;
		it.tsel = tsel;
		it.idx = rgb2s_pkg::IDX_W'(idx);
		it.value = v;
		it.r = rgb2s_pkg::PIX_W'($urandom);
		it.g = rgb2s_pkg::PIX_W'($urandom);
		it.b = rgb2s_pkg::PIX_W'($urandom);
		return it;
	endfunction

	function automatic stim_t pixel_item(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		stim_t it;
		it.mode = rgb2s_pkg::MODE_PIXEL;
		it.tsel = 2'($urandom);
		it.idx = rgb2s_pkg::IDX_W'($urandom);
		it.value = $urandom;
		it.r = r;
		it.g = g;
		it.b = b;
		return it;
	endfunction

	function automatic logic [7:0] rand_comp();
		case ($urandom_range(9))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic stim_t rand_item();
		int p;
		logic [1:0] tsel;
		int idx;
		p = $urandom_range(99);
		if (p < 28) return pixel_item(rand_comp(), rand_comp(), rand_comp());
		tsel = (p < 31) ? 2'd3 : 2'($urandom_range(2));
		case (tsel)
			rgb2s_pkg::TSEL_ADAPT: idx = $urandom_range(rgb2s_pkg::ADAPT_DEPTH - 1);
			rgb2s_pkg::TSEL_CORR:  idx = $urandom_range(rgb2s_pkg::CORR_DEPTH - 1);
			default:               idx = $urandom_range(rgb2s_pkg::BASIS_DEPTH - 1);
		endcase
		if ($urandom_range(19) == 0) idx = $urandom_range(4095);
		return coef_item(tsel, idx, pick_coef());
	endfunction

	// input driver
	always @(negedge clk) begin
		stim_t it;
		if (arst_n && (!in_valid || in_fire)) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
				it = pending_items.pop_front();
				mode <= it.mode;
				table_select <= it.tsel;
				coef_index <= it.idx;
				coef_value <= it.value;
				red <= it.r;
				green <= it.g;
				blue <= it.b;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result stall
	always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle);

	// monitor: accept input, check results, watchdog
	always @(posedge clk) begin
		stim_t it;
		spec_t want;
		bit moved;
		moved = 1'b0;
		in_fire <= in_valid && !in_stall;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				it.mode = mode;
				it.tsel = table_select;
				it.idx = coef_index;
				it.value = coef_value;
				it.r = red;
				it.g = green;
				it.b = blue;
				absorb_item(it);
				moved = 1'b1;
			end
			if (cfg_valid && cfg_ready) moved = 1'b1;
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				if (spectra_due.size() == 0) begin
					report_mismatch("unexpected result", spectral_value, 32'd0);
				end else begin
					want = spectra_due.pop_front();
					pixels_checked++;
					if (want.sat) sat_results++;
					if (spectral_value !== want.value)
						report_mismatch("spectral_value", spectral_value, want.value);
					if (saturated !== want.sat)
						report_mismatch("saturated", 32'(saturated), 32'(want.sat));
				end
			end
			quiet_cycles <= moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", WDOG_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic set_wavelength(logic [rgb2s_pkg::WL_W-1:0] wl);
		@(negedge clk);
		wavelength_index <= wl;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		wl_sel = wl;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || in_valid || spectra_due.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// sequence of phases
	initial begin
		logic [rgb2s_pkg::WL_W-1:0] wl_list[8];
		int wl_row;
		for (int c = 0; c < 256; c++) gamma_tab[c] = gamma_calc(c);
		xyz_fix = '{4124564, 3575761, 1804375, 2126729, 7151522, 721750, 193339, 1191920,
			9503041};
		for (int i = 0; i < 9; i++) xyz_fix[i] = (xyz_fix[i] * 16777216 + 5000000) / 10000000;
		wl_list = '{9'd0, 9'd400, 9'd511, 9'd1, 9'd399, 9'($urandom_range(400)),
			9'($urandom_range(401, 511)), 9'($urandom_range(400))};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		set_wavelength(wl_list[0]);

		// load the matrices and every basis row that a pixel will read
		for (int i = 0; i < rgb2s_pkg::ADAPT_DEPTH; i++)
			pending_items.push_back(coef_item(rgb2s_pkg::TSEL_ADAPT, i,
				(i % 4 == 0) ? 32'h0100_0000 : {{11{1'b0}}, 21'($urandom)}));
		for (int i = 0; i < rgb2s_pkg::CORR_DEPTH; i++)
			pending_items.push_back(coef_item(rgb2s_pkg::TSEL_CORR, i,
				(i == 1 || i == 22 || i == 43) ? 32'h0100_0000 : {{15{1'b0}}, 17'($urandom)}));
		for (int j = 0; j < 8; j++) begin
			wl_row = (wl_list[j] >= rgb2s_pkg::NUM_WAVELENGTHS)
				? rgb2s_pkg::NUM_WAVELENGTHS - 1 : int'(wl_list[j]);
			for (int k = 0; k < rgb2s_pkg::NUM_BASIS_TERMS; k++)
				pending_items.push_back(coef_item(rgb2s_pkg::TSEL_BASIS,
					wl_row * rgb2s_pkg::NUM_BASIS_TERMS + k, pick_coef()));
		end

		// directed: pixel extremes, gamma knee, ignored writes, full-scale words
		pending_items.push_back(pixel_item(8'd0, 8'd0, 8'd0));
		pending_items.push_back(pixel_item(8'd255, 8'd255, 8'd255));
		pending_items.push_back(pixel_item(8'd10, 8'd11, 8'd10));
		pending_items.push_back(pixel_item(8'd255, 8'd0, 8'd128));
		pending_items.push_back(pixel_item(8'haa, 8'h55, 8'h01));
		pending_items.push_back(coef_item(2'd3, 0, 32'hdead_beef));
		pending_items.push_back(coef_item(rgb2s_pkg::TSEL_ADAPT, rgb2s_pkg::ADAPT_DEPTH,
			32'h7fff_ffff));
		pending_items.push_back(coef_item(rgb2s_pkg::TSEL_CORR, rgb2s_pkg::CORR_DEPTH,
			32'h8000_0000));
		pending_items.push_back(coef_item(rgb2s_pkg::TSEL_BASIS, rgb2s_pkg::BASIS_DEPTH,
			32'hffff_ffff));
		pending_items.push_back(coef_item(rgb2s_pkg::TSEL_BASIS, 4095, 32'h1234_5678));
		pending_items.push_back(pixel_item(8'd200, 8'd100, 8'd50));
		pending_items.push_back(coef_item(rgb2s_pkg::TSEL_BASIS, 3, 32'h7fff_ffff));
		pending_items.push_back(coef_item(rgb2s_pkg::TSEL_CORR, 1, 32'h7fff_ffff));
		pending_items.push_back(pixel_item(8'd255, 8'd255, 8'd255));
		pending_items.push_back(coef_item(rgb2s_pkg::TSEL_ADAPT, 0, 32'h8000_0000));
		pending_items.push_back(pixel_item(8'd255, 8'd255, 8'd255));
		pending_items.push_back(pixel_item(8'd1, 8'd0, 8'd0));
		drain();

		// random traffic under each idle mix and several wavelengths
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0;  recv_idle = 0;  end
				1: begin send_idle = 81; recv_idle = 0;  end
				2: begin send_idle = 0;  recv_idle = 81; end
				default: begin send_idle = 22; recv_idle = 22; end
			endcase
			set_wavelength(wl_list[ph]);
			for (int n = 0; n < 250; n++) pending_items.push_back(rand_item());
			drain();
		end
		repeat (50) @(posedge clk);

		$display("covered %0d pixel results (%0d saturated) and %0d coefficient writes",
			pixels_checked, sat_results, coef_writes);
		$display("over eight wavelength settings and four idle/stall mixes");
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- rgb_to_spectral_reconstruction_top.f -----
rtl/core/rgb2s_pkg.sv
rtl/core/rgb2s_ram.sv
rtl/core/rgb2s_front.sv
rtl/core/rgb2s_back.sv
rtl/core/rgb_to_spectral_reconstruction_top.sv
tb/tb_rgb_to_spectral_reconstruction_top.sv
